@@ hw/rtl/tfq_pkg.sv @@
// ----------------------------------------------------------------------------
// tfq_pkg
// Shared types and constants of the transmit frame queue with repeat scheduler.
// ----------------------------------------------------------------------------
package tfq_pkg;

    localparam int QUEUE_DEPTH   = 64;
    localparam int PAYLOAD_BYTES = 8;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int PAY_W  = 8 * PAYLOAD_BYTES;
    localparam int ID_W   = 29;
    localparam int DATA_W = 64;
    localparam int TIME_W = 32;
    localparam int LVL_W  = 7;
    localparam int ENT_W  = ID_W + PAY_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_TOTAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_GAP   = 1'b1;

    localparam logic REQ_ENQUEUE = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [ID_W-1:0]   frame_id;
        logic [DATA_W-1:0] frame_data;
        logic [TIME_W-1:0] now_ms;
        logic              tx_ready;
    } t_tfq_req;

    typedef struct packed {
        logic              frame_sent;
        logic [ID_W-1:0]   out_id;
        logic [DATA_W-1:0] out_data;
        logic              enqueue_dropped;
        logic [LVL_W-1:0]  queue_level;
        logic              active_busy;
    } t_tfq_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FETCH
    } t_tfq_state;

    typedef struct packed {
        logic capture;
        logic enq;
        logic fetch;
        logic tick;
        logic load;
    } t_tfq_cmd;

    typedef struct packed {
        logic req_tick;
        logic need_load;
    } t_tfq_sts;

endpackage

@@ hw/rtl/tx_frame_queue_repeat_scheduler.sv @@
// ----------------------------------------------------------------------------
// tx_frame_queue_repeat_scheduler
// Transmit frame queue with repeat scheduling of each dequeued frame.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a request (enqueue or tick) is taken on a clock edge with
//   start high and busy low. Enqueues store id and payload in a 64-entry ring
//   RAM; ticks carry time and controller readiness and may send a frame.
//   Result channel: o_done strobes for one cycle with o_res. Every request
//   gives exactly one result. The receiver cannot stall; results are never
//   held back.
//   Config: i_cfg_we writes repeat total (index 0) or repeat gap (index 1);
//   user writes only while the block is idle (not enforced); no read-back.
//   Timing: an enqueue, or a tick that does not load the head, is captured in
//   ST_IDLE and executed in ST_EXEC, which sets o_done, with busy low again in
//   that cycle; the block can take a new request while o_done is high.
//   A tick that loads the head frame adds ST_FETCH after ST_EXEC,
//   the extra state covering the registered read of the queue RAM.
//   Reset: synchronous, active low; queue empty, no active frame, repeat
//   total 1 and gap 100 ms. The queue RAM itself is not cleared.
// ----------------------------------------------------------------------------
module tx_frame_queue_repeat_scheduler import tfq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_tfq_req              i_req,
    output logic                  o_done,
    output t_tfq_res              o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_tfq_cmd cmd;
    t_tfq_sts sts;

    tfq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tfq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_done      (o_done),
        .o_res       (o_res)
    );

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer did not raise busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result while still busy");
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");
`endif

endmodule

@@ hw/rtl/tfq_ram.sv @@
// ----------------------------------------------------------------------------
// tfq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/tfq_ctrl.sv @@
// ----------------------------------------------------------------------------
// tfq_ctrl
// Sequencer: accepts a request, then drives enqueue, head fetch and tick steps.
// ----------------------------------------------------------------------------
module tfq_ctrl import tfq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_tfq_sts i_sts,
    output t_tfq_cmd o_cmd
);

    t_tfq_state r_state;
    t_tfq_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!i_sts.req_tick) begin
                    o_cmd.enq = 1'b1;
                    n_state   = ST_IDLE;
                end else if (i_sts.need_load) begin
                    o_cmd.fetch = 1'b1;
                    n_state     = ST_FETCH;
                end else begin
                    o_cmd.tick = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_FETCH: begin
                o_cmd.tick = 1'b1;
                o_cmd.load = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

`ifndef ASSERT_OFF
    a_fetch_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fetch |=> (o_cmd.tick && o_cmd.load))
        else $error("head fetch not followed by load");
    a_load_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> $past(o_cmd.fetch))
        else $error("load without fetch");
    a_capture_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (o_cmd.enq || o_cmd.fetch || o_cmd.tick))
        else $error("captured request not executed");
`endif

endmodule

@@ hw/rtl/tfq_dp.sv @@
// ----------------------------------------------------------------------------
// tfq_dp
// Datapath: config registers, ring pointers, queue RAM, active frame and
// repeat timing, result register.
// ----------------------------------------------------------------------------
module tfq_dp import tfq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_tfq_req              i_req,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  t_tfq_cmd              i_cmd,
    output t_tfq_sts              o_sts,
    output logic                  o_done,
    output t_tfq_res              o_res
);

    logic [7:0]        r_repeat_total;
    logic [15:0]       r_repeat_gap;
    t_tfq_req          r_req;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [CNT_W-1:0]  r_fill;
    logic [ID_W-1:0]   r_cur_id;
    logic [PAY_W-1:0]  r_cur_pay;
    logic              r_cur_valid;
    logic [7:0]        r_sends;
    logic [TIME_W-1:0] r_due;
    logic              r_done;
    t_tfq_res          r_res;

    logic              full;
    logic              wr_en;
    logic [ENT_W-1:0]  ram_wdata;
    logic [ENT_W-1:0]  ram_rdata;

    logic              eff_valid;
    logic [ID_W-1:0]   eff_id;
    logic [PAY_W-1:0]  eff_pay;
    logic [7:0]        eff_sends;
    logic [TIME_W-1:0] eff_due;
    logic [TIME_W-1:0] diff;
    logic              send;
    logic [7:0]        sends_dec;

    logic [CNT_W-1:0]  n_fill;
    logic              n_cur_valid;
    t_tfq_res          n_res;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_total <= 8'd1;
            r_repeat_gap   <= 16'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_REPEAT_TOTAL: r_repeat_total <= i_cfg_wdata[7:0];
                REG_REPEAT_GAP:   r_repeat_gap   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
    end

    assign full      = (r_fill == CNT_W'(QUEUE_DEPTH));
    assign wr_en     = i_cmd.enq && !full;
    assign ram_wdata = {r_req.frame_id, r_req.frame_data[PAY_W-1:0]};

    tfq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_wr_ptr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.fetch),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    assign o_sts.req_tick  = (r_req.req_type == REQ_TICK);
    assign o_sts.need_load = !r_cur_valid && (r_fill != '0);

    always_comb begin
        if (i_cmd.load) begin
            eff_valid = 1'b1;
            eff_id    = ram_rdata[ENT_W-1:PAY_W];
            eff_pay   = ram_rdata[PAY_W-1:0];
            eff_sends = (r_repeat_total == 8'd0) ? 8'd1 : r_repeat_total;
            eff_due   = r_req.now_ms;
        end else begin
            eff_valid = r_cur_valid;
            eff_id    = r_cur_id;
            eff_pay   = r_cur_pay;
            eff_sends = r_sends;
            eff_due   = r_due;
        end
        diff      = r_req.now_ms - eff_due;
        send      = eff_valid && !diff[TIME_W-1] && r_req.tx_ready;
        sends_dec = eff_sends - 8'd1;

        n_fill      = r_fill;
        n_cur_valid = r_cur_valid;
        if (wr_en) begin
            n_fill = r_fill + 1'b1;
        end
        if (i_cmd.tick) begin
            if (i_cmd.load) begin
                n_fill = r_fill - 1'b1;
            end
            n_cur_valid = eff_valid && !(send && sends_dec == 8'd0);
        end

        n_res                 = '0;
        n_res.frame_sent      = i_cmd.tick && send;
        n_res.out_id          = (i_cmd.tick && send) ? eff_id : '0;
        n_res.out_data        = (i_cmd.tick && send) ? DATA_W'(eff_pay) : '0;
        n_res.enqueue_dropped = i_cmd.enq && full;
        n_res.queue_level     = LVL_W'(n_fill);
        n_res.active_busy     = n_cur_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_fill      <= '0;
            r_cur_valid <= 1'b0;
            r_cur_id    <= '0;
            r_cur_pay   <= '0;
            r_sends     <= '0;
            r_due       <= '0;
            r_done      <= 1'b0;
        end else begin
            r_done <= i_cmd.enq || i_cmd.tick;
            r_fill <= n_fill;
            if (wr_en) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_cmd.tick) begin
                r_cur_valid <= n_cur_valid;
                r_cur_id    <= eff_id;
                r_cur_pay   <= eff_pay;
                r_sends     <= send ? sends_dec : eff_sends;
                r_due       <= send ? r_req.now_ms + TIME_W'(r_repeat_gap) : eff_due;
                if (i_cmd.load) begin
                    r_rd_ptr <= ptr_next(r_rd_ptr);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enq || i_cmd.tick) begin
            r_res <= n_res;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count above depth");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PTR_W'(r_wr_ptr - r_rd_ptr) == PTR_W'(r_fill))
        else $error("pointers disagree with fill count");
    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_res.frame_sent) |-> (o_res.out_id == '0 && o_res.out_data == '0))
        else $error("frame fields set without a send");
    a_load_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fetch |-> (r_fill != '0 && !r_cur_valid))
        else $error("head fetch from empty queue or with active frame");
`endif

endmodule

@@ tb/tb_tx_frame_queue_repeat_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tx_frame_queue_repeat_scheduler
// Self-checking bench for the transmit frame queue with repeat scheduling.
// Each enqueue or tick transfer is mirrored in a local scheduler model. Every
// result strobe is compared field by field with the oldest expected result.
// Directed cases, a queue overflow, then random phases under several repeat
// settings, with random request gaps and a gap-free tail.
// ----------------------------------------------------------------------------
module tb_tx_frame_queue_repeat_scheduler;
    import tfq_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 4;
    localparam logic [DATA_W-1:0] PAY_MASK = {DATA_W{1'b1}} >> (DATA_W - PAY_W);

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    t_tfq_req              i_req       = '0;
    logic                  o_done;
    t_tfq_res              o_res;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // scheduler model state
    logic [7:0]        m_repeat_total;
    logic [15:0]       m_repeat_gap;
    logic [ID_W-1:0]   m_q_id   [QUEUE_DEPTH];
    logic [DATA_W-1:0] m_q_data [QUEUE_DEPTH];
    int                m_rd;
    int                m_wr;
    int                m_fill;
    logic [ID_W-1:0]   m_cur_id;
    logic [DATA_W-1:0] m_cur_data;
    logic              m_cur_valid;
    logic [7:0]        m_sends_left;
    logic [TIME_W-1:0] m_due;

    logic [TIME_W-1:0] now_cur;
    bit                idle_en;
    t_tfq_res          exp_res_q[$];
    int                err_cnt     = 0;
    int                idle_cycles = 0;

    tx_frame_queue_repeat_scheduler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_tfq_res schedule_step(t_tfq_req r);
        t_tfq_res          res;
        logic [TIME_W-1:0] lag;
        res = '0;
        if (r.req_type == REQ_ENQUEUE) begin
            if (m_fill >= QUEUE_DEPTH) begin
                res.enqueue_dropped = 1'b1;
            end else begin
                m_q_id[m_wr]   = r.frame_id;
                m_q_data[m_wr] = r.frame_data & PAY_MASK;
                m_wr           = (m_wr + 1) % QUEUE_DEPTH;
                m_fill++;
            end
        end else begin
            if (!m_cur_valid && m_fill > 0) begin
                m_cur_id     = m_q_id[m_rd];
                m_cur_data   = m_q_data[m_rd];
                m_rd         = (m_rd + 1) % QUEUE_DEPTH;
                m_fill--;
                m_cur_valid  = 1'b1;
                m_sends_left = (m_repeat_total == 8'd0) ? 8'd1 : m_repeat_total;
                m_due        = r.now_ms;
            end
            lag = r.now_ms - m_due;
            if (m_cur_valid && !lag[TIME_W-1] && r.tx_ready) begin
                res.frame_sent = 1'b1;
                res.out_id     = m_cur_id;
                res.out_data   = m_cur_data;
                m_sends_left--;
                if (m_sends_left == 8'd0) begin
                    m_cur_valid = 1'b0;
                end else begin
                    m_due = r.now_ms + TIME_W'(m_repeat_gap);
                end
            end
        end
        res.queue_level = LVL_W'(m_fill);
        res.active_busy = m_cur_valid;
        return res;
    endfunction

    function automatic t_tfq_req make_req(logic kind, logic [ID_W-1:0] id,
                                          logic [DATA_W-1:0] data,
                                          logic [TIME_W-1:0] now, logic rdy);
        t_tfq_req r;
        r.req_type   = kind;
        r.frame_id   = id;
        r.frame_data = data;
        r.now_ms     = now;
        r.tx_ready   = rdy;
        return r;
    endfunction

    // ticks move the clock on mostly forwards; the odd arbitrary jump is noise
    function automatic t_tfq_req rand_req(int enq_pct);
        t_tfq_req r;
        r.frame_id   = ID_W'($urandom);
        r.frame_data = {$urandom, $urandom};
        r.now_ms     = $urandom;
        r.tx_ready   = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < enq_pct) begin
            r.req_type = REQ_ENQUEUE;
        end else begin
            r.req_type = REQ_TICK;
            case ($urandom_range(0, 9))
                0: ;
                1: now_cur = $urandom;
                2, 3: now_cur = now_cur + TIME_W'(m_repeat_gap);
                default: now_cur = now_cur + $urandom_range(0, m_repeat_gap + 3);
            endcase
            r.now_ms   = now_cur;
            r.tx_ready = ($urandom_range(0, 3) != 0);
        end
        return r;
    endfunction

    task automatic send_req(t_tfq_req r);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        exp_res_q.push_back(schedule_step(r));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (exp_res_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_DATA_W-1:0] total_word,
                             logic [CFG_DATA_W-1:0] gap_word);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_REPEAT_TOTAL;
        i_cfg_wdata <= total_word;
        @(posedge i_clk);
        i_cfg_idx   <= REG_REPEAT_GAP;
        i_cfg_wdata <= gap_word;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        m_repeat_total = total_word[7:0];
        m_repeat_gap   = gap_word;
    endtask

    task automatic test_directed();
        idle_en = 1'b1;
        now_cur = 32'h0000_1000;
        // reset settings: one send per frame
        send_req(make_req(REQ_TICK, '1, '1, now_cur, 1'b1));
        send_req(make_req(REQ_ENQUEUE, '0, '0, '1, 1'b1));
        send_req(make_req(REQ_ENQUEUE, '1, '1, '0, 1'b0));
        send_req(make_req(REQ_ENQUEUE, 29'h0AAA_AAAA, 64'h5555_5555_5555_5555, '0, 1'b0));
        send_req(make_req(REQ_TICK, '0, '0, now_cur, 1'b0));
        send_req(make_req(REQ_TICK, '0, '0, now_cur + 1, 1'b1));
        send_req(make_req(REQ_TICK, '0, '0, 32'hFFFF_FFFF, 1'b1));
        send_req(make_req(REQ_TICK, '1, '1, 32'h8000_0000, 1'b1));
        // three sends, due times across the wrap of the ms counter
        write_cfg(16'h0003, 16'd100);
        send_req(make_req(REQ_ENQUEUE, 29'h1555_5555, 64'hAAAA_AAAA_AAAA_AAAA, '0, 1'b0));
        send_req(make_req(REQ_TICK, '0, '0, 32'hFFFF_FFC0, 1'b1));
        send_req(make_req(REQ_TICK, '0, '0, 32'hFFFF_FFFF, 1'b1));
        send_req(make_req(REQ_TICK, '0, '0, 32'h0000_0023, 1'b1));
        send_req(make_req(REQ_TICK, '0, '0, 32'h0000_0024, 1'b0));
        send_req(make_req(REQ_TICK, '0, '0, 32'h0000_0024, 1'b1));
        send_req(make_req(REQ_TICK, '0, '0, 32'h0000_0088, 1'b1));
        // repeat total of zero behaves as one
        write_cfg(16'hFF00, 16'hFFFF);
        send_req(make_req(REQ_ENQUEUE, 29'h0123_4567, 64'h0123_4567_89AB_CDEF, '0, 1'b0));
        send_req(make_req(REQ_TICK, '0, '0, 32'h0000_0100, 1'b1));
        send_req(make_req(REQ_TICK, '0, '0, 32'h0000_0200, 1'b1));
        // zero gap: due again on the same ms
        write_cfg(16'h0002, 16'h0000);
        send_req(make_req(REQ_ENQUEUE, 29'h1FED_CBA9, 64'hFEDC_BA98_7654_3210, '0, 1'b0));
        send_req(make_req(REQ_TICK, '0, '0, 32'h0000_0300, 1'b1));
        send_req(make_req(REQ_TICK, '0, '0, 32'h0000_0300, 1'b1));
    endtask

    task automatic test_queue_overflow();
        write_cfg(16'h0001, 16'($urandom_range(0, 20)));
        now_cur = $urandom;
        repeat (QUEUE_DEPTH + 3) send_req(rand_req(100));
        repeat (QUEUE_DEPTH + 16) send_req(rand_req(0));
    endtask

    task automatic test_random_phases();
        logic [CFG_DATA_W-1:0] totals   [5] = '{16'd3, 16'd255, 16'd0, 16'd2, 16'd7};
        logic [CFG_DATA_W-1:0] gaps     [5] = '{16'd10, 16'd0, 16'd65535, 16'd65535, 16'd1};
        int                    enq_pcts [5] = '{40, 30, 50, 45, 35};
        for (int k = 0; k < 5; k++) begin
            write_cfg({8'($urandom), totals[k][7:0]}, gaps[k]);
            now_cur = $urandom;
            repeat (350) send_req(rand_req(enq_pcts[k]));
        end
    endtask

    task automatic test_no_idle_tail();
        write_cfg(16'($urandom), 16'($urandom_range(0, 50)));
        idle_en = 1'b0;
        now_cur = $urandom;
        repeat (250) send_req(rand_req(40));
    endtask

    function automatic void compare_field(string fname, logic [DATA_W-1:0] exp_v,
                                          logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v) begin
            err_cnt++;
            if (err_cnt <= 50)
                $display("%0t: %s mismatch: expected %h, actual %h",
                         $time, fname, exp_v, act_v);
        end
    endfunction

    always @(posedge i_clk) begin
        t_tfq_res exp_r;
        if (i_rst_n && o_done) begin
            if (exp_res_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 50)
                    $display("%0t: result with no transfer pending: expected none, actual %h",
                             $time, o_res);
            end else begin
                exp_r = exp_res_q.pop_front();
                compare_field("frame_sent", exp_r.frame_sent, o_res.frame_sent);
                compare_field("out_id", exp_r.out_id, o_res.out_id);
                compare_field("out_data", exp_r.out_data, o_res.out_data);
                compare_field("enqueue_dropped", exp_r.enqueue_dropped, o_res.enqueue_dropped);
                compare_field("queue_level", exp_r.queue_level, o_res.queue_level);
                compare_field("active_busy", exp_r.active_busy, o_res.active_busy);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || i_cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        m_repeat_total = 8'd1;
        m_repeat_gap   = 16'd100;
        m_rd           = 0;
        m_wr           = 0;
        m_fill         = 0;
        m_cur_id       = '0;
        m_cur_data     = '0;
        m_cur_valid    = 1'b0;
        m_sends_left   = 8'd0;
        m_due          = '0;
        idle_en        = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_queue_overflow();
        test_random_phases();
        test_no_idle_tail();
        drain_results();

        if (err_cnt == 0 && exp_res_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
